// ----- rtl/core/sscrr_pkg.sv -----
// Package with the geometry constants and seven-segment helpers for the clock row raster.
`timescale 1ns / 1ps

package sscrr_pkg;

  localparam int unsigned RowW    = 7;
  localparam int unsigned ValW    = 7;
  localparam int unsigned PixW    = 32;
  localparam int unsigned RelW    = 6;
  localparam int unsigned InDataW = 24;

  localparam logic [RowW-1:0] HoursTop   = 7'd10;
  localparam logic [RowW-1:0] MinutesTop = 7'd73;
  localparam logic [RowW-1:0] DigitRows  = 7'd36;
  localparam logic [RowW-1:0] Dot1Top    = 7'd53;
  localparam logic [RowW-1:0] Dot2Top    = 7'd62;
  localparam logic [4:0]      TensX      = 5'd1;
  localparam logic [4:0]      UnitsX     = 5'd17;
  localparam logic [4:0]      DotX       = 5'd14;

  // Segment bits: top, upper right, lower right, bottom, lower left, upper left, middle.
  localparam logic [6:0] SegTop = 7'h40;
  localparam logic [6:0] SegUr  = 7'h20;
  localparam logic [6:0] SegLr  = 7'h10;
  localparam logic [6:0] SegBot = 7'h08;
  localparam logic [6:0] SegLl  = 7'h04;
  localparam logic [6:0] SegUl  = 7'h02;
  localparam logic [6:0] SegMid = 7'h01;

  typedef logic [PixW-1:0] pix_t;

  function automatic logic [6:0] seg_of(input logic [3:0] digit);
    logic [6:0] s;
    case (digit)
      4'd0:    s = 7'h7E;
      4'd1:    s = 7'h30;
      4'd2:    s = 7'h6D;
      4'd3:    s = 7'h79;
      4'd4:    s = 7'h33;
      4'd5:    s = 7'h5B;
      4'd6:    s = 7'h5F;
      4'd7:    s = 7'h70;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h7B;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // Pixel mask of one digit on one row; rel is the row offset from the digit's top.
  function automatic pix_t digit_row(input logic [3:0] digit, input logic [4:0] x,
                                     input logic [RelW-1:0] rel);
    logic [6:0] s;
    pix_t hbar;
    pix_t left;
    pix_t right;
    pix_t m;
    s     = seg_of(digit);
    hbar  = 32'h0000_07FF << ({1'b0, x} + 6'd1);
    left  = 32'h0000_0003 << x;
    right = 32'h0000_0003 << ({1'b0, x} + 6'd11);
    m     = '0;
    if (rel <= 6'd1) begin
      if ((s & SegTop) != '0) m = m | hbar;
    end else if (rel <= 6'd16) begin
      if ((s & SegUl) != '0) m = m | left;
      if ((s & SegUr) != '0) m = m | right;
    end else if (rel <= 6'd18) begin
      if ((s & SegMid) != '0) m = m | hbar;
    end else if (rel <= 6'd33) begin
      if ((s & SegLl) != '0) m = m | left;
      if ((s & SegLr) != '0) m = m | right;
    end else if (rel <= 6'd35) begin
      if ((s & SegBot) != '0) m = m | hbar;
    end
    return m;
  endfunction

  // Both digits of a value; tens above nine wrap round modulo ten.
  function automatic pix_t pair_row(input logic [ValW-1:0] value, input logic [RelW-1:0] rel);
    logic [17:0] prod;
    logic [3:0]  tens;
    logic [3:0]  tens_dig;
    logic [6:0]  units;
    prod     = {11'd0, value} * 18'd205;
    tens     = prod[14:11];
    units    = value - ({3'd0, tens} * 7'd10);
    tens_dig = (tens >= 4'd10) ? tens - 4'd10 : tens;
    return digit_row(tens_dig, TensX, rel) | digit_row(units[3:0], UnitsX, rel);
  endfunction

endpackage

// ----- rtl/core/seven_segment_clock_row_raster_top.sv -----
// Top level of the seven-segment clock row raster, with output register and skid stage.
`timescale 1ns / 1ps

//  channel  direction  word contents
//  s_*      in         row_index, hours, minutes, colon_lit in s_tdata
//  m_*      out        row_pixels in m_tdata
//
// The mask is decoded from the input word and stored in the output register,
// so a new word is accepted in every cycle while the skid register is empty.
// Reset clears the output and skid valid flags; the block is ready from the
// first cycle after reset. While the output is stalled one further word is
// held in the skid register, and s_tready drops until it drains.
module seven_segment_clock_row_raster_top
  import sscrr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [InDataW-1:0] s_tdata,  // row_index[6:0], hours[13:7], minutes[20:14], colon_lit[21]
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [PixW-1:0]    m_tdata   // row_pixels[31:0]
);

  logic [RowW-1:0] row_index;
  logic [ValW-1:0] hours;
  logic [ValW-1:0] minutes;
  logic            colon_lit;
  logic [RowW-1:0] hrel;
  logic [RowW-1:0] mrel;
  pix_t            pixels;

  logic            out_valid;
  pix_t            out_data;
  logic            skid_valid;
  pix_t            skid_data;
  logic            accept;

  assign row_index = s_tdata[6:0];
  assign hours     = s_tdata[13:7];
  assign minutes   = s_tdata[20:14];
  assign colon_lit = s_tdata[21];

  assign hrel = row_index - HoursTop;
  assign mrel = row_index - MinutesTop;

  always_comb begin
    pixels = '0;
    if (row_index >= HoursTop && hrel < DigitRows) begin
      pixels = pixels | pair_row(hours, hrel[RelW-1:0]);
    end
    if (row_index >= MinutesTop && mrel < DigitRows) begin
      pixels = pixels | pair_row(minutes, mrel[RelW-1:0]);
    end
    if (colon_lit && ((row_index >= Dot1Top && row_index < Dot1Top + 7'd4) ||
                      (row_index >= Dot2Top && row_index < Dot2Top + 7'd4))) begin
      pixels = pixels | (32'h0000_000F << DotX);
    end
  end

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || m_tready) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= accept;
        end else begin
          out_valid <= accept;
        end
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (accept) begin
          skid_data <= pixels;
        end
      end else if (accept) begin
        out_data <= pixels;
      end
    end else if (accept) begin
      skid_data <= pixels;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("The skid word is held while the output register is empty.");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    (accept && out_valid && !m_tready) |=> skid_valid)
    else $error("A word accepted during a stall was not kept in the skid register.");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && m_tready) |=> out_valid)
    else $error("The skid word was lost when the output drained.");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && m_tready && !accept) |=> (out_data == $past(skid_data)))
    else $error("The output register did not take the skid word.");

endmodule
